// ----- rtl/rlpe_pkg.sv -----
// Shared types, constants and the LED profile table for the RGB LED pulse encoder.
package rlpe_pkg;

   localparam int unsigned ColorWidth = 24;
   localparam int unsigned TicksWidth = 4;
   localparam int unsigned LedTypeWidth = 2;
   localparam int unsigned ItemsPerPixel = 24;
   localparam int unsigned ItemCountWidth = $clog2(ItemsPerPixel);
   localparam logic [ItemCountWidth-1:0] LastItem = ItemCountWidth'(ItemsPerPixel - 1);

   localparam int unsigned QueueDepth = 2;
   localparam int unsigned QueuePtrWidth = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
   localparam int unsigned QueueCountWidth = $clog2(QueueDepth + 1);

   localparam int unsigned CsrDataWidth = 32;
   localparam int unsigned CsrAddrWidth = 3;

   typedef enum logic [LedTypeWidth-1:0] {
      LED_WS2812 = 2'd0,
      LED_SK6812 = 2'd1,
      LED_APA106 = 2'd2
   } led_kind_type;

   // Register index of the LED type register.
   localparam logic [CsrAddrWidth-3:0] RegLedType = '0;

   typedef struct packed {
      logic [ColorWidth-1:0] color;
      logic                  end_of_strip;
   } req_type;

   typedef struct packed {
      logic [TicksWidth-1:0] mark_ticks;
      logic [TicksWidth-1:0] space_ticks;
      logic                  last;
      logic                  frame_end;
   } rsp_type;

   typedef struct packed {
      logic [TicksWidth-1:0] one_high;
      logic [TicksWidth-1:0] one_low;
      logic [TicksWidth-1:0] zero_high;
      logic [TicksWidth-1:0] zero_low;
      logic                  red_first;
   } profile_type;

   // One classified pixel: the bits in wire order plus the timing to use.
   typedef struct packed {
      logic [ColorWidth-1:0] word;
      profile_type           profile;
      logic                  end_of_strip;
   } job_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

   function automatic profile_type led_profile(input logic [LedTypeWidth-1:0] kind);
      profile_type p;
      unique case (kind)
         LED_WS2812: p = '{4'd9, 4'd3, 4'd3, 4'd9, 1'b0};
         LED_SK6812: p = '{4'd6, 4'd6, 4'd3, 4'd9, 1'b0};
         LED_APA106: p = '{4'd14, 4'd3, 4'd3, 4'd14, 1'b1};
         default:    p = '{4'd9, 4'd3, 4'd3, 4'd9, 1'b0};
      endcase
      return p;
   endfunction

endpackage

// ----- rtl/rgb_led_pulse_encoder.sv -----
// Top level of the RGB LED pulse encoder: register port, front, queue and back.
//
//   channel   ports                         moves
//   request   req_push, req_full, req_data  one pixel (color, end_of_strip)
//   response  rsp_pop, rsp_empty, rsp_data  one pulse item (ticks, last, frame_end)
//   config    csr_p*                        LED type register at byte address 0
//
// Each pixel yields 24 pulse items, one per cycle when the response side pops on every cycle,
// and the back serializer takes the next pixel as the final item of the one before leaves.
// The first item of a pixel is shown once the pixel has passed the front register, the queue
// and the back register. The front register and a two-entry queue let the request side run
// ahead of a stalled response side by up to three pixels. Synchronous reset empties every
// stage and sets the LED type to WS2812.
module rgb_led_pulse_encoder (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_push,
   output logic                                 req_full,
   input  rlpe_pkg::req_type                    req_data,
   output logic                                 rsp_empty,
   input  logic                                 rsp_pop,
   output rlpe_pkg::rsp_type                    rsp_data,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [rlpe_pkg::CsrAddrWidth-1:0]    csr_paddr,
   input  logic [rlpe_pkg::CsrDataWidth-1:0]    csr_pwdata,
   output logic [rlpe_pkg::CsrDataWidth-1:0]    csr_prdata,
   output logic                                 csr_pready
);

   logic [rlpe_pkg::LedTypeWidth-1:0] led_type_ff, led_type_in;
   logic                              csr_write, sel_led_type;
   logic                              q_push, q_pop;
   rlpe_pkg::job_type                 q_wdata, q_rdata;
   rlpe_pkg::q_status_type            q_status;

   assign csr_pready   = 1'b1;
   assign sel_led_type = (csr_paddr[rlpe_pkg::CsrAddrWidth-1:2] == rlpe_pkg::RegLedType);
   assign csr_write    = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign led_type_in  = (csr_write && sel_led_type)
                         ? csr_pwdata[rlpe_pkg::LedTypeWidth-1:0] : led_type_ff;
   assign csr_prdata   = sel_led_type
                         ? {{(rlpe_pkg::CsrDataWidth-rlpe_pkg::LedTypeWidth){1'b0}}, led_type_ff}
                         : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         led_type_ff <= rlpe_pkg::LED_WS2812;
      end else begin
         led_type_ff <= led_type_in;
      end
   end

   rlpe_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_push (req_push),
      .req_full (req_full),
      .req_data (req_data),
      .led_type (led_type_ff),
      .q_status (q_status),
      .q_push   (q_push),
      .q_data   (q_wdata)
   );

   rlpe_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_wdata),
      .pop       (q_pop),
      .pop_data  (q_rdata),
      .status    (q_status)
   );

   rlpe_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_status  (q_status),
      .q_data    (q_rdata),
      .q_pop     (q_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

   // A pixel stays on the response side until its final item has been transferred.
   a_pixel_held: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_pop && !rsp_data.last) |=> !rsp_empty)
      else $error("response went empty in the middle of a pixel");

   // The end-of-strip mark only appears on the final item of a pixel.
   a_frame_end_last: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_data.frame_end) |-> rsp_data.last)
      else $error("frame_end raised on an item that is not last");

   // The back never takes from an empty queue.
   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_status.empty)
      else $error("back stage popped an empty queue");

   // Reset leaves nothing to deliver.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> (rsp_empty && !req_full))
      else $error("pipeline not empty after reset");

endmodule

// ----- rtl/rlpe_front.sv -----
// Front stage: accepts a pixel, picks the LED profile and reorders the color bytes.
module rlpe_front (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_push,
   output logic                                 req_full,
   input  rlpe_pkg::req_type                    req_data,
   input  logic [rlpe_pkg::LedTypeWidth-1:0]    led_type,
   input  rlpe_pkg::q_status_type               q_status,
   output logic                                 q_push,
   output rlpe_pkg::job_type                    q_data
);

   logic              valid_ff, valid_in;
   rlpe_pkg::job_type job_ff, job_in;
   rlpe_pkg::profile_type prof;
   logic              accept;
   logic [7:0]        red, green, blue;

   assign req_full = valid_ff && q_status.full;
   assign accept   = req_push && !req_full;
   assign q_push   = valid_ff && !q_status.full;
   assign q_data   = job_ff;

   assign red   = req_data.color[23:16];
   assign green = req_data.color[15:8];
   assign blue  = req_data.color[7:0];

   always_comb begin
      prof                = rlpe_pkg::led_profile(led_type);
      job_in.profile      = prof;
      job_in.end_of_strip = req_data.end_of_strip;
      if (prof.red_first) begin
         job_in.word = {red, green, blue};
      end else begin
         job_in.word = {green, red, blue};
      end
   end

   always_comb begin
      valid_in = valid_ff;
      if (accept) begin
         valid_in = 1'b1;
      end else if (q_push) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         job_ff <= job_in;
      end
   end

endmodule

// ----- rtl/rlpe_queue.sv -----
// Short queue of classified pixels between the front and back stages.
module rlpe_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  rlpe_pkg::job_type       push_data,
   input  logic                    pop,
   output rlpe_pkg::job_type       pop_data,
   output rlpe_pkg::q_status_type  status
);

   rlpe_pkg::job_type mem [rlpe_pkg::QueueDepth];

   logic [rlpe_pkg::QueuePtrWidth-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [rlpe_pkg::QueuePtrWidth-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [rlpe_pkg::QueueCountWidth-1:0] count_ff, count_in;
   logic do_push, do_pop;

   localparam logic [rlpe_pkg::QueuePtrWidth-1:0] PtrLast =
      rlpe_pkg::QueuePtrWidth'(rlpe_pkg::QueueDepth - 1);
   localparam logic [rlpe_pkg::QueueCountWidth-1:0] CountFull =
      rlpe_pkg::QueueCountWidth'(rlpe_pkg::QueueDepth);

   assign status.full  = (count_ff == CountFull);
   assign status.empty = (count_ff == '0);
   assign do_push      = push && !status.full;
   assign do_pop       = pop && !status.empty;
   assign pop_data     = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrLast) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrLast) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ----- rtl/rlpe_back.sv -----
// Back stage: shifts a classified pixel out as 24 pulse items, one per transfer.
module rlpe_back (
   input  logic                    clock,
   input  logic                    reset,
   input  rlpe_pkg::q_status_type  q_status,
   input  rlpe_pkg::job_type       q_data,
   output logic                    q_pop,
   output logic                    rsp_empty,
   input  logic                    rsp_pop,
   output rlpe_pkg::rsp_type       rsp_data
);

   logic                                   active_ff, active_in;
   logic [rlpe_pkg::ColorWidth-1:0]        word_ff, word_in;
   logic [rlpe_pkg::ItemCountWidth-1:0]    count_ff, count_in;
   rlpe_pkg::profile_type                  prof_ff, prof_in;
   logic                                   eos_ff, eos_in;
   logic                                   is_last, take, free;

   assign is_last   = (count_ff == rlpe_pkg::LastItem);
   assign take      = active_ff && rsp_pop;
   // The back is free for a new pixel when idle or when the final item leaves now.
   assign free      = !active_ff || (take && is_last);
   assign q_pop     = free && !q_status.empty;
   assign rsp_empty = !active_ff;

   always_comb begin
      active_in = active_ff;
      word_in   = word_ff;
      count_in  = count_ff;
      prof_in   = prof_ff;
      eos_in    = eos_ff;
      if (q_pop) begin
         active_in = 1'b1;
         word_in   = q_data.word;
         count_in  = '0;
         prof_in   = q_data.profile;
         eos_in    = q_data.end_of_strip;
      end else if (take && is_last) begin
         active_in = 1'b0;
      end else if (take) begin
         word_in  = {word_ff[rlpe_pkg::ColorWidth-2:0], 1'b0};
         count_in = count_ff + 1'b1;
      end
   end

   always_comb begin
      if (word_ff[rlpe_pkg::ColorWidth-1]) begin
         rsp_data.mark_ticks  = prof_ff.one_high;
         rsp_data.space_ticks = prof_ff.one_low;
      end else begin
         rsp_data.mark_ticks  = prof_ff.zero_high;
         rsp_data.space_ticks = prof_ff.zero_low;
      end
      rsp_data.last      = is_last;
      rsp_data.frame_end = is_last && eos_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         active_ff <= active_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
      prof_ff <= prof_in;
      eos_ff  <= eos_in;
   end

endmodule
